// ===== rtl/iec_pkg.sv =====
// shared types and constants of the infix calculator
package iec_pkg;

  localparam int DataWidth = 32;

  typedef enum logic [3:0] {
    PH_LEAD, PH_FIRST, PH_PREOP, PH_LT, PH_GT, PH_POSTOP, PH_SECOND, PH_TAIL, PH_ERR, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR
  } op_t;

  typedef enum logic [1:0] {EV_IDLE, EV_DIV, EV_FIN} ev_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SYN  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [8:0] INIT_LEFT  = 9'h1F0;
  localparam logic [8:0] INIT_RIGHT = 9'h1EF;

  // one finished line handed from parser to evaluator
  typedef struct packed {
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    op_t                  op;
    logic                 syn_err;
  } job_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [8:0]  left_display;
    logic [8:0]  right_display;
  } res_t;

endpackage

// ===== rtl/iec_parser.sv =====
// front end: character parser that emits one job per line end
module iec_parser import iec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  phase_t               ph_r, ph_nxt;
  logic [DataWidth-1:0] a_r, a_nxt, b_r, b_nxt;
  op_t                  op_r, op_nxt;
  logic                 blank, digit, eol, acc;
  logic [DataWidth-1:0] dval, acc_src, acc_val;

  assign blank = (char_code == 8'd32) || (char_code == 8'd9);
  assign digit = (char_code >= 8'd48) && (char_code <= 8'd57);
  assign eol   = (char_code == 8'd13) || (char_code == 8'd10);
  assign in_ready = !eol || job_ready;
  assign acc = in_valid && in_ready;
  assign dval = DataWidth'(char_code - 8'd48);
  assign acc_src = (ph_r == PH_FIRST) ? a_r : (ph_r == PH_SECOND) ? b_r : '0;
  assign acc_val = (acc_src << 3) + (acc_src << 1) + dval;

  assign job_valid = in_valid && eol;
  assign job.a = a_r;
  assign job.b = b_r;
  assign job.op = op_r;
  assign job.syn_err = !(ph_r == PH_SECOND || ph_r == PH_TAIL || ph_r == PH_DONE);

  always_comb begin
    ph_nxt = ph_r;
    a_nxt  = a_r;
    b_nxt  = b_r;
    op_nxt = op_r;
    if (acc) begin
      if (eol) begin
        ph_nxt = PH_LEAD;
        a_nxt  = '0;
        b_nxt  = '0;
        op_nxt = OP_NONE;
      end else if (ph_r == PH_ERR || ph_r == PH_DONE) begin
        ph_nxt = ph_r;
      end else if (char_code == 8'd0) begin
        ph_nxt = (ph_r == PH_SECOND || ph_r == PH_TAIL) ? PH_DONE : PH_ERR;
      end else begin
        ph_nxt = PH_ERR;
        unique case (ph_r)
          PH_LEAD: begin
            if (blank) ph_nxt = PH_LEAD;
            else if (digit) begin a_nxt = acc_val; ph_nxt = PH_FIRST; end
          end
          PH_FIRST, PH_PREOP: begin
            if (ph_r == PH_FIRST && digit) begin a_nxt = acc_val; ph_nxt = PH_FIRST; end
            else if (blank) ph_nxt = PH_PREOP;
            else if (char_code == 8'd60) ph_nxt = PH_LT;
            else if (char_code == 8'd62) ph_nxt = PH_GT;
            else if (char_code == 8'd43) begin op_nxt = OP_ADD; ph_nxt = PH_POSTOP; end
            else if (char_code == 8'd45) begin op_nxt = OP_SUB; ph_nxt = PH_POSTOP; end
            else if (char_code == 8'd42) begin op_nxt = OP_MUL; ph_nxt = PH_POSTOP; end
            else if (char_code == 8'd47) begin op_nxt = OP_DIV; ph_nxt = PH_POSTOP; end
            else if (char_code == 8'd37) begin op_nxt = OP_MOD; ph_nxt = PH_POSTOP; end
          end
          PH_LT: if (char_code == 8'd60) begin op_nxt = OP_SHL; ph_nxt = PH_POSTOP; end
          PH_GT: if (char_code == 8'd62) begin op_nxt = OP_SHR; ph_nxt = PH_POSTOP; end
          PH_POSTOP: begin
            if (blank) ph_nxt = PH_POSTOP;
            else if (digit) begin b_nxt = acc_val; ph_nxt = PH_SECOND; end
          end
          PH_SECOND: begin
            if (digit) begin b_nxt = acc_val; ph_nxt = PH_SECOND; end
            else if (blank) ph_nxt = PH_TAIL;
          end
          PH_TAIL: if (blank) ph_nxt = PH_TAIL;
          default: ph_nxt = PH_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_LEAD;
      a_r  <= '0;
      b_r  <= '0;
      op_r <= OP_NONE;
    end else begin
      ph_r <= ph_nxt;
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

// ===== rtl/iec_fifo.sv =====
// two-entry job queue between parser and evaluator
module iec_fifo import iec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== rtl/iec_eval.sv =====
// back end: evaluator with a bit-serial divider and a result register
module iec_eval import iec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  localparam int W  = DataWidth;
  localparam int CW = $clog2(W + 1);

  ev_t          st_r, st_nxt;
  logic [W-1:0] q_r, rem_r, d_r, r_r;
  logic [CW-1:0] cnt_r;
  logic         an_r, bn_r, mod_r, dz_r, syn_r;
  logic [W-1:0] ma, mb, r_fast;
  logic [CW-1:0] sh;
  logic [W:0]   trial;
  logic         an, bn, big, is_div, res_full;
  logic [1:0]   stat;
  res_t         res_r;
  logic         ovalid_r;
  logic [W-1:0] fin_val, fin_neg;
  logic [31:0]  full;

  assign an = job.a[W-1];
  assign bn = job.b[W-1];
  assign ma = an ? -job.a : job.a;
  assign mb = bn ? -job.b : job.b;
  assign big = job.b >= W'(W);
  assign sh  = job.b[CW-1:0];
  assign is_div = (job.op == OP_DIV) || (job.op == OP_MOD);
  assign res_full = ovalid_r && !out_ready;

  always_comb begin
    r_fast = '0;
    case (job.op)
      OP_ADD: r_fast = job.a + job.b;
      OP_SUB: r_fast = job.a - job.b;
      OP_MUL: r_fast = W'(job.a * job.b);
      OP_SHL: r_fast = big ? '0 : job.a << sh;
      OP_SHR: r_fast = big ? {W{an}} : W'($signed(job.a) >>> sh);
      default: r_fast = '0;
    endcase
  end

  assign job_ready = (st_r == EV_IDLE) && !res_full;
  assign trial = {rem_r, q_r[W-1]} - {1'b0, d_r};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      EV_IDLE: if (job_valid && job_ready)
                 st_nxt = (is_div && !job.syn_err && job.b != '0) ? EV_DIV : EV_FIN;
      EV_DIV:  if (cnt_r == CW'(1)) st_nxt = EV_FIN;
      EV_FIN:  if (!res_full) st_nxt = EV_IDLE;
      default: st_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      EV_IDLE: if (job_valid && job_ready) begin
        syn_r <= job.syn_err || job.op == OP_NONE;
        dz_r  <= is_div && job.b == '0;
        mod_r <= job.op == OP_MOD;
        an_r  <= an;
        bn_r  <= bn;
        q_r   <= ma;
        rem_r <= '0;
        d_r   <= mb;
        cnt_r <= CW'(W);
        r_r   <= r_fast;
      end
      EV_DIV: begin
        cnt_r <= cnt_r - CW'(1);
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-2:0], q_r[W-1]};
          q_r   <= {q_r[W-2:0], 1'b0};
        end
      end
      EV_FIN: if (st_nxt == EV_IDLE && cnt_r == '0 && !syn_r && !dz_r) begin
        if (mod_r) r_r <= an_r ? -rem_r : rem_r;
        else       r_r <= (an_r != bn_r) ? -q_r : q_r;
      end
      default: ;
    endcase
  end

  // final value: divide path writes r_r only as EV_FIN ends, so pick directly here
  always_comb begin
    if (cnt_r == '0 && !syn_r && !dz_r)
      fin_val = mod_r ? (an_r ? -rem_r : rem_r) : ((an_r != bn_r) ? -q_r : q_r);
    else
      fin_val = r_r;
  end
  assign fin_neg = -fin_val;
  assign full = 32'($signed(fin_val));

  always_comb begin
    if (syn_r) stat = ST_SYN;
    else if (dz_r) stat = ST_DIV0;
    else if (fin_val[W-1]) stat = (fin_neg > W'(12'hFFF)) ? ST_OVF : ST_OK;
    else stat = (fin_val > W'(16'hFFFF)) ? ST_OVF : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (st_r == EV_FIN && !res_full) begin
      res_r.value  <= (stat == ST_SYN || stat == ST_DIV0) ? 32'd0 : full;
      res_r.status <= stat;
      res_r.left_display  <= (stat == ST_OK) ? {1'b0, fin_val[15:8]} : INIT_LEFT;
      res_r.right_display <= (stat == ST_OK) ? {1'b0, fin_val[7:0]} : INIT_RIGHT;
    end
    if (!rst_n) begin
      st_r     <= EV_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == EV_FIN && !res_full) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
  assign res = res_r;

endmodule

// ===== rtl/infix_expression_calculator.sv =====
// top level of the serial infix integer calculator
// Usage:
//  in_*: one ASCII character per item (in_tdata[7:0] = char_code).
//  out_*: one result item per CR or LF character.
//  The parser takes one character a cycle; a line end waits only while the
//  two-entry job queue is full. The evaluator passes add, subtract, multiply
//  and shifts from its idle state straight to its finish state; divide and
//  remainder first run the one-bit-a-cycle restoring divider. The result
//  register loads in the finish state.
//  The result register holds its item while out_tready is low; the evaluator
//  and then the queue stall behind it, and the parser keeps taking characters
//  until a line end finds the queue full.
//  Reset (rst_n low, synchronous) empties queue and result register and returns
//  the parser to the start of a line.
//  Results: value 32-bit signed, status 0 ok, 1 syntax, 2 divide by zero,
//  3 overflow, plus two 9-bit display codes.
module infix_expression_calculator import iec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [31:0] value, [33:32] status,
                                  // [42:34] left_display, [51:43] right_display
);

  logic pj_valid, pj_ready, ej_valid, ej_ready;
  job_t pj, ej;
  res_t res;

  iec_parser u_parser (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .char_code(in_tdata), .job_valid(pj_valid), .job_ready(pj_ready), .job(pj)
  );

  iec_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(pj_valid), .wr_ready(pj_ready), .wr_job(pj),
    .rd_valid(ej_valid), .rd_ready(ej_ready), .rd_job(ej)
  );

  iec_eval u_eval (
    .clk(clk), .rst_n(rst_n), .job_valid(ej_valid), .job_ready(ej_ready), .job(ej),
    .out_valid(out_tvalid), .out_ready(out_tready), .res(res)
  );

  assign out_tdata = {4'd0, res.right_display, res.left_display, res.status, res.value};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != ST_OK |-> out_tdata[42:34] == INIT_LEFT)
    else $error("error result without initials code");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:32] == ST_SYN || out_tdata[33:32] == ST_DIV0)
    |-> out_tdata[31:0] == 32'd0)
    else $error("error result with nonzero value");

endmodule
